// ===== rtl/pleg_pkg.sv =====
// Shared types, constants and codes for the piecewise linear envelope gain block.
package pleg_pkg;

  localparam int SAMPLE_BITS     = 24;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEVEL_BITS      = 16;
  localparam int GAIN_BITS       = 16;
  localparam int GAIN_FRAC       = 15;
  localparam int CFG_IDX_BITS    = 3;
  localparam int SEG_BITS        = 3;

  localparam logic [LEVEL_BITS-1:0] ATTACK_LVL_RST  = LEVEL_BITS'(32768);
  localparam logic [LEVEL_BITS-1:0] DECAY_LVL_RST   = LEVEL_BITS'(16384);
  localparam logic [LEVEL_BITS-1:0] SUSTAIN_LVL_RST = LEVEL_BITS'(16384);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_LEN  = 3'd0,
    REG_DECAY_LEN   = 3'd1,
    REG_SUSTAIN_LEN = 3'd2,
    REG_RELEASE_LEN = 3'd3,
    REG_ATTACK_LVL  = 3'd4,
    REG_DECAY_LVL   = 3'd5,
    REG_SUSTAIN_LVL = 3'd6
  } cfg_reg_e;

  typedef enum logic [SEG_BITS-1:0] {
    SEG_ATTACK  = 3'd0,
    SEG_DECAY   = 3'd1,
    SEG_SUSTAIN = 3'd2,
    SEG_RELEASE = 3'd3,
    SEG_DONE    = 3'd4
  } seg_e;

  typedef struct packed {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [SEG_BITS-1:0]           segment;
  } out_beat_t;

endpackage

// ===== rtl/pleg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ramp interpolation.
module pleg_div import pleg_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [GAIN_BITS+LENGTH_BITS-1:0] dividend_i,
  input  logic [LENGTH_BITS-1:0]           divisor_i,
  output logic                             busy_o,
  output logic [GAIN_BITS-1:0]             quot_o
);

  localparam int CntW = $clog2(GAIN_BITS + 1);

  logic [CntW-1:0]        cnt_q;
  logic [LENGTH_BITS-1:0] rem_q;
  logic [LENGTH_BITS-1:0] dsr_q;
  logic [GAIN_BITS-1:0]   dvd_q;
  logic [LENGTH_BITS:0]   trial;
  logic                   fits;

  assign trial  = {rem_q, dvd_q[GAIN_BITS-1]};
  assign fits   = trial >= {1'b0, dsr_q};
  assign busy_o = cnt_q != '0;
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(GAIN_BITS);
    end else if (busy_o) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // The quotient is known to fit GAIN_BITS, so the top part starts below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[GAIN_BITS+LENGTH_BITS-1:GAIN_BITS];
      dvd_q <= dividend_i[GAIN_BITS-1:0];
      dsr_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= fits ? LENGTH_BITS'(trial - {1'b0, dsr_q}) : trial[LENGTH_BITS-1:0];
      dvd_q <= {dvd_q[GAIN_BITS-2:0], fits};
    end
  end

endmodule

// ===== rtl/pleg_sat.sv =====
// Rounding and saturation of the scaled sample product.
module pleg_sat import pleg_pkg::*; #(
  parameter int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1
) (
  input  logic signed [PROD_BITS-1:0]   prod_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam logic signed [PROD_BITS-1:0] RoundHalf = PROD_BITS'(1 << (GAIN_FRAC - 1));
  localparam logic signed [PROD_BITS-1:0] SatHi =
    PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PROD_BITS-1:0] SatLo = -SatHi - PROD_BITS'(1);

  logic signed [PROD_BITS-1:0] rnd;
  logic signed [PROD_BITS-1:0] shr;

  // Add half, then floor with the arithmetic shift: halves round upwards.
  assign rnd = prod_i + RoundHalf;
  assign shr = rnd >>> GAIN_FRAC;

  always_comb begin
    if (shr > SatHi) begin
      sample_o = SatHi[SAMPLE_BITS-1:0];
    end else if (shr < SatLo) begin
      sample_o = SatLo[SAMPLE_BITS-1:0];
    end else begin
      sample_o = shr[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/piecewise_linear_envelope_gain.sv =====
// Envelope gain top level: configuration, segment sequencer, output register.
// Gain item: segment select, multiply, divider start, the 16-step divider, gain, scale, output.
// Finished item: segment select, then output; restart item: position back to 0, no result.
// Throughput: one restart per cycle while idle; any other item stalls the input until it is done.
// A result held by the receiver stalls the next item in its last step until the register frees.
// Reset: lengths 0, levels 32768/16384/16384, position 0, output empty.
module piecewise_linear_envelope_gain import pleg_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int CFG_BITS    = (LENGTH_BITS > LEVEL_BITS) ? LENGTH_BITS : LEVEL_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_beat_t                in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_beat_t               out_data_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [CFG_BITS-1:0]     cfg_wdata_i
);

  localparam int PosW = LENGTH_BITS + 2;
  localparam int MulW = GAIN_BITS + LENGTH_BITS;
  localparam int ProdW = SAMPLE_BITS + GAIN_BITS + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_SEG, S_MUL, S_DIVST, S_DIV, S_GAIN, S_SCALE, S_OUT
  } state_e;

  state_e state_q;

  logic [LENGTH_BITS-1:0] atk_len_q, dec_len_q, sus_len_q, rel_len_q;
  logic [LEVEL_BITS-1:0]  atk_lvl_q, dec_lvl_q, sus_lvl_q;
  logic [PosW-1:0]        pos_q;

  logic signed [SAMPLE_BITS-1:0] smp_q;
  seg_e                          seg_q;
  logic                          dir_q;
  logic [LEVEL_BITS-1:0]         start_q;
  logic [GAIN_BITS-1:0]          mag_q;
  logic [LENGTH_BITS-1:0]        off_q;
  logic [LENGTH_BITS-1:0]        len_q;
  logic [MulW-1:0]               mul_q;
  logic signed [GAIN_BITS:0]     gain_q;
  logic signed [ProdW-1:0]       scl_q;

  logic      out_valid_q;
  out_beat_t out_q;

  // Segment selection
  logic [PosW-1:0]        e0, e1, e2, e3;
  seg_e                   seg_d;
  logic [LEVEL_BITS-1:0]  lvl_start, lvl_end;
  logic [LENGTH_BITS-1:0] seg_len;
  logic [PosW-1:0]        seg_base;
  logic signed [LEVEL_BITS:0] delta;

  logic                   div_start, div_busy;
  logic [GAIN_BITS-1:0]   div_quot;
  logic signed [SAMPLE_BITS-1:0] sat_smp;
  logic                   in_acc, out_free;

  assign e0 = PosW'(atk_len_q);
  assign e1 = e0 + PosW'(dec_len_q);
  assign e2 = e1 + PosW'(sus_len_q);
  assign e3 = e2 + PosW'(rel_len_q);

  always_comb begin
    seg_d     = SEG_DONE;
    lvl_start = '0;
    lvl_end   = '0;
    seg_len   = atk_len_q;
    seg_base  = '0;
    if (pos_q < e0) begin
      seg_d   = SEG_ATTACK;
      lvl_end = atk_lvl_q;
    end else if (pos_q < e1) begin
      seg_d     = SEG_DECAY;
      lvl_start = atk_lvl_q;
      lvl_end   = dec_lvl_q;
      seg_len   = dec_len_q;
      seg_base  = e0;
    end else if (pos_q < e2) begin
      seg_d     = SEG_SUSTAIN;
      lvl_start = dec_lvl_q;
      lvl_end   = sus_lvl_q;
      seg_len   = sus_len_q;
      seg_base  = e1;
    end else if (pos_q < e3) begin
      seg_d     = SEG_RELEASE;
      lvl_start = sus_lvl_q;
      seg_len   = rel_len_q;
      seg_base  = e2;
    end
  end

  assign delta = $signed({1'b0, lvl_end}) - $signed({1'b0, lvl_start});

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = state_q == S_DIVST;

  pleg_div #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(mul_q),
    .divisor_i (len_q),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  pleg_sat #(
    .PROD_BITS(ProdW)
  ) u_sat (
    .prod_i  (scl_q),
    .sample_o(sat_smp)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atk_len_q <= '0;
      dec_len_q <= '0;
      sus_len_q <= '0;
      rel_len_q <= '0;
      atk_lvl_q <= ATTACK_LVL_RST;
      dec_lvl_q <= DECAY_LVL_RST;
      sus_lvl_q <= SUSTAIN_LVL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ATTACK_LEN:  atk_len_q <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_DECAY_LEN:   dec_len_q <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_SUSTAIN_LEN: sus_len_q <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_RELEASE_LEN: rel_len_q <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_ATTACK_LVL:  atk_lvl_q <= cfg_wdata_i[LEVEL_BITS-1:0];
        REG_DECAY_LVL:   dec_lvl_q <= cfg_wdata_i[LEVEL_BITS-1:0];
        REG_SUSTAIN_LVL: sus_lvl_q <= cfg_wdata_i[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with its control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Load a new beat when the register frees, otherwise drop the taken one
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data_i.kind) begin
              pos_q <= '0;
            end else begin
              state_q <= S_SEG;
            end
          end
        end
        S_SEG: begin
          if (seg_d == SEG_DONE) begin
            state_q <= S_OUT;
          end else begin
            pos_q   <= pos_q + PosW'(1);
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_DIVST;
        S_DIVST: state_q <= S_DIV;
        S_DIV: begin
          if (!div_busy) begin
            state_q <= S_GAIN;
          end
        end
        S_GAIN:  state_q <= S_SCALE;
        S_SCALE: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= in_data_i.sample_in;
    end
    if (state_q == S_SEG) begin
      seg_q   <= seg_d;
      dir_q   <= delta[LEVEL_BITS];
      start_q <= lvl_start;
      mag_q   <= delta[LEVEL_BITS] ? GAIN_BITS'(-delta) : GAIN_BITS'(delta);
      off_q   <= LENGTH_BITS'(pos_q - seg_base);
      len_q   <= seg_len;
      scl_q   <= '0;
    end
    if (state_q == S_MUL) begin
      mul_q <= MulW'(mag_q) * MulW'(off_q);
    end
    if (state_q == S_GAIN) begin
      gain_q <= dir_q ? $signed({1'b0, start_q}) - $signed({1'b0, div_quot})
                      : $signed({1'b0, start_q}) + $signed({1'b0, div_quot});
    end
    if (state_q == S_SCALE) begin
      scl_q <= ProdW'(smp_q) * ProdW'(gain_q);
    end
    if (state_q == S_OUT && out_free) begin
      out_q.sample_out <= sat_smp;
      out_q.segment    <= seg_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
